FILE: design/csi_pkg.sv
// ----------------------------------------------------------------------------
// csi_pkg: shared types and constants of the cubic spline interpolator
// Field widths, interpolation mode codes and saturation bounds.
// ----------------------------------------------------------------------------
package csi_pkg;

    localparam int CTRL_W = 32;  // control value and result width
    localparam int AMT_W  = 17;  // amount width
    localparam int MODE_W = 2;   // mode register width

    // interpolation mode register codes
    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_SMOOTH  = 2'd1,
        MODE_CATMULL = 2'd2,
        MODE_HERMITE = 2'd3
    } t_mode;

    localparam t_mode MODE_RESET = MODE_CATMULL;

    // saturation bounds of the result
    localparam logic [CTRL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [CTRL_W-1:0] VAL_MIN = 32'h8000_0000;

endpackage

FILE: design/cubic_spline_interpolator.sv
// ----------------------------------------------------------------------------
// cubic_spline_interpolator: one curve coordinate per word
// Linear, smooth-step, Catmull-Rom or cubic Hermite evaluation of four
// fixed-point control values at parameter t, saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | i_valid / o_ready   | i_ctrl0..i_ctrl3, i_amount
//  output   | o_valid / i_ready   | o_value, o_overflow
//  config   | i_cfg_we            | i_cfg_data (interp mode)
//
//  Seven register stages, the last of them the output register.
//  One word per cycle sustained while the output is not stalled; stage five
//  holds the four weight multipliers, one per product term.
//  A stage takes a new word whenever it is empty or its successor moves, so
//  bubbles close up while the output is stalled and nothing is lost.
//  Synchronous active-low reset empties the pipeline and sets Catmull-Rom.
// ----------------------------------------------------------------------------
module cubic_spline_interpolator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [csi_pkg::MODE_W-1:0]  i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [csi_pkg::CTRL_W-1:0] i_ctrl0,
    input  logic signed [csi_pkg::CTRL_W-1:0] i_ctrl1,
    input  logic signed [csi_pkg::CTRL_W-1:0] i_ctrl2,
    input  logic signed [csi_pkg::CTRL_W-1:0] i_ctrl3,
    input  logic [csi_pkg::AMT_W-1:0]   i_amount,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [csi_pkg::CTRL_W-1:0] o_value,
    output logic                        o_overflow
);
    import csi_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int NST   = 7;                                  // pipeline depth
    localparam int TW    = (F + 1 < AMT_W) ? F + 1 : AMT_W;    // clamped t
    localparam int TT_W  = 2 * TW + 1;                         // t*t plus round
    localparam int SW    = F + 2;                              // smooth factor
    localparam int SP_W  = TW + SW + 1;                        // t2*m plus round
    localparam int D_W   = CTRL_W + 1;                         // differences
    localparam int A_W   = CTRL_W + 4;                         // mult operand
    localparam int W_W   = F + 3;                              // weights
    localparam int ACC_W = A_W + W_W;                          // product and sum

    localparam logic [31:0]        ONE32    = 32'd1 << F;
    localparam logic [TT_W-1:0]    HALF_TT  = TT_W'(1) << (F - 1);
    localparam logic [SP_W-1:0]    HALF_SP  = SP_W'(1) << (F - 1);
    localparam logic [SW-1:0]      THREE_1  = SW'(3) << F;
    localparam logic signed [W_W-1:0] ONE_W = W_W'(1) << F;
    localparam logic signed [ACC_W-1:0] HALF_F  = ACC_W'(1) << (F - 1);
    localparam logic signed [ACC_W-1:0] HALF_F1 = ACC_W'(1) << F;

    // ------------------------------------------------------------------
    // Stage enables: a stage moves when empty or when its successor moves
    // ------------------------------------------------------------------
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Mode register
    // ------------------------------------------------------------------
    t_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp t, square it, form the spline coefficients
    // ------------------------------------------------------------------
    logic [31:0]             n_t_wide;
    logic [TW-1:0]           n_t;
    logic signed [A_W-1:0]   n_e0, n_e1, n_e2, n_e3;

    t_mode                   r_s1_mode;
    logic [TW-1:0]           r_s1_t;
    logic [2*TW-1:0]         r_s1_tt;
    logic signed [CTRL_W-1:0] r_s1_c0, r_s1_c1, r_s1_c2, r_s1_c3;
    logic signed [D_W-1:0]   r_s1_d10, r_s1_dcr;
    logic signed [A_W-1:0]   r_s1_k2, r_s1_k3;

    always_comb begin
        n_t_wide = (32'(i_amount) > ONE32) ? ONE32 : 32'(i_amount);
        n_t      = n_t_wide[TW-1:0];
        n_e0     = A_W'(i_ctrl0);
        n_e1     = A_W'(i_ctrl1);
        n_e2     = A_W'(i_ctrl2);
        n_e3     = A_W'(i_ctrl3);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_mode <= r_mode;
            r_s1_t    <= n_t;
            r_s1_tt   <= n_t * n_t;
            r_s1_c0   <= i_ctrl0;
            r_s1_c1   <= i_ctrl1;
            r_s1_c2   <= i_ctrl2;
            r_s1_c3   <= i_ctrl3;
            r_s1_d10  <= D_W'(i_ctrl1) - D_W'(i_ctrl0);
            r_s1_dcr  <= D_W'(i_ctrl2) - D_W'(i_ctrl0);
            r_s1_k2   <= (n_e0 <<< 1) - (n_e1 <<< 2) - n_e1 + (n_e2 <<< 2) - n_e3;
            r_s1_k3   <= (n_e1 <<< 1) + n_e1 - (n_e2 <<< 1) - n_e2 + n_e3 - n_e0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round t squared
    // ------------------------------------------------------------------
    logic [TT_W-1:0]         n_tt_rnd;
    logic [TT_W-1:0]         n_tt_sh;

    t_mode                   r_s2_mode;
    logic [TW-1:0]           r_s2_t, r_s2_t2;
    logic signed [CTRL_W-1:0] r_s2_c0, r_s2_c1, r_s2_c2, r_s2_c3;
    logic signed [D_W-1:0]   r_s2_d10, r_s2_dcr;
    logic signed [A_W-1:0]   r_s2_k2, r_s2_k3;

    always_comb begin
        n_tt_rnd = {1'b0, r_s1_tt} + HALF_TT;
        n_tt_sh  = n_tt_rnd >> F;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s2_mode <= r_s1_mode;
            r_s2_t    <= r_s1_t;
            r_s2_t2   <= n_tt_sh[TW-1:0];
            r_s2_c0   <= r_s1_c0;
            r_s2_c1   <= r_s1_c1;
            r_s2_c2   <= r_s1_c2;
            r_s2_c3   <= r_s1_c3;
            r_s2_d10  <= r_s1_d10;
            r_s2_dcr  <= r_s1_dcr;
            r_s2_k2   <= r_s1_k2;
            r_s2_k3   <= r_s1_k3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: t cubed and the smooth-step product, unrounded
    // ------------------------------------------------------------------
    logic [SW-1:0]           n_m;

    t_mode                   r_s3_mode;
    logic [TW-1:0]           r_s3_t, r_s3_t2;
    logic [2*TW-1:0]         r_s3_t3p;
    logic [TW+SW-1:0]        r_s3_sp;
    logic signed [CTRL_W-1:0] r_s3_c0, r_s3_c1, r_s3_c2, r_s3_c3;
    logic signed [D_W-1:0]   r_s3_d10, r_s3_dcr;
    logic signed [A_W-1:0]   r_s3_k2, r_s3_k3;

    assign n_m = THREE_1 - (SW'(r_s2_t) << 1);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s3_mode <= r_s2_mode;
            r_s3_t    <= r_s2_t;
            r_s3_t2   <= r_s2_t2;
            r_s3_t3p  <= r_s2_t2 * r_s2_t;
            r_s3_sp   <= r_s2_t2 * n_m;
            r_s3_c0   <= r_s2_c0;
            r_s3_c1   <= r_s2_c1;
            r_s3_c2   <= r_s2_c2;
            r_s3_c3   <= r_s2_c3;
            r_s3_d10  <= r_s2_d10;
            r_s3_dcr  <= r_s2_dcr;
            r_s3_k2   <= r_s2_k2;
            r_s3_k3   <= r_s2_k3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round, build the weights, pick operands for the mode
    // ------------------------------------------------------------------
    logic [TT_W-1:0]         n_t3_rnd, n_t3_sh;
    logic [SP_W-1:0]         n_s_rnd, n_s_sh;
    logic signed [W_W-1:0]   n_te, n_t2e, n_t3e, n_se;
    logic signed [W_W-1:0]   n_wa, n_wb, n_wc, n_wd;
    logic signed [A_W-1:0]   n_a0, n_a1, n_a2, n_a3;
    logic signed [W_W-1:0]   n_w0, n_w1, n_w2, n_w3;
    logic signed [ACC_W-1:0] n_base;
    logic                    n_cat;

    logic signed [A_W-1:0]   r_s4_a0, r_s4_a1, r_s4_a2, r_s4_a3;
    logic signed [W_W-1:0]   r_s4_w0, r_s4_w1, r_s4_w2, r_s4_w3;
    logic signed [ACC_W-1:0] r_s4_base;
    logic                    r_s4_cat;

    always_comb begin
        n_t3_rnd = {1'b0, r_s3_t3p} + HALF_TT;
        n_t3_sh  = n_t3_rnd >> F;
        n_s_rnd  = {1'b0, r_s3_sp} + HALF_SP;
        n_s_sh   = n_s_rnd >> F;

        n_te  = $signed(W_W'(r_s3_t));
        n_t2e = $signed(W_W'(r_s3_t2));
        n_t3e = $signed(W_W'(n_t3_sh[TW-1:0]));
        n_se  = $signed(W_W'(n_s_sh[SW-1:0]));

        // Hermite basis weights
        n_wa = (n_t3e <<< 1) - (n_t2e <<< 1) - n_t2e + ONE_W;
        n_wb = (n_t2e <<< 1) + n_t2e - (n_t3e <<< 1);
        n_wc = n_t3e - (n_t2e <<< 1) + n_te;
        n_wd = n_t3e - n_t2e;

        n_a0   = A_W'(r_s3_d10);
        n_a1   = '0;
        n_a2   = '0;
        n_a3   = '0;
        n_w0   = n_te;
        n_w1   = '0;
        n_w2   = '0;
        n_w3   = '0;
        n_base = ((ACC_W'(r_s3_c0)) <<< F) | HALF_F;
        n_cat  = 1'b0;

        case (r_s3_mode)
            MODE_LINEAR: begin
                n_w0 = n_te;
            end
            MODE_SMOOTH: begin
                n_w0 = n_se;
            end
            MODE_CATMULL: begin
                n_a0   = A_W'(r_s3_dcr);
                n_a1   = r_s3_k2;
                n_a2   = r_s3_k3;
                n_w1   = n_t2e;
                n_w2   = n_t3e;
                n_base = ((ACC_W'(r_s3_c1)) <<< (F + 1)) | HALF_F1;
                n_cat  = 1'b1;
            end
            MODE_HERMITE: begin
                n_a0   = A_W'(r_s3_c0);
                n_a1   = A_W'(r_s3_c2);
                n_a2   = A_W'(r_s3_c1);
                n_a3   = A_W'(r_s3_c3);
                n_w0   = n_wa;
                n_w1   = n_wb;
                n_w2   = n_wc;
                n_w3   = n_wd;
                n_base = HALF_F;
            end
            default: begin
                n_cat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s4_a0   <= n_a0;
            r_s4_a1   <= n_a1;
            r_s4_a2   <= n_a2;
            r_s4_a3   <= n_a3;
            r_s4_w0   <= n_w0;
            r_s4_w1   <= n_w1;
            r_s4_w2   <= n_w2;
            r_s4_w3   <= n_w3;
            r_s4_base <= n_base;
            r_s4_cat  <= n_cat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: weight products
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_s5_p0, r_s5_p1, r_s5_p2, r_s5_p3;
    logic signed [ACC_W-1:0] r_s5_base;
    logic                    r_s5_cat;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s5_p0   <= r_s4_a0 * r_s4_w0;
            r_s5_p1   <= r_s4_a1 * r_s4_w1;
            r_s5_p2   <= r_s4_a2 * r_s4_w2;
            r_s5_p3   <= r_s4_a3 * r_s4_w3;
            r_s5_base <= r_s4_base;
            r_s5_cat  <= r_s4_cat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: accumulate products, base term and rounding half
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_s6_sum;
    logic                    r_s6_cat;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s6_sum <= r_s5_p0 + r_s5_p1 + r_s5_p2 + r_s5_p3 + r_s5_base;
            r_s6_cat <= r_s5_cat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: scale down and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] n_sh;
    logic                    n_fits;
    logic signed [CTRL_W-1:0] r_out_value;
    logic                    r_out_ovf;

    always_comb begin
        n_sh   = r_s6_cat ? (r_s6_sum >>> (F + 1)) : (r_s6_sum >>> F);
        n_fits = (&n_sh[ACC_W-1:CTRL_W-1]) || !(|n_sh[ACC_W-1:CTRL_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_out_ovf <= !n_fits;
            if (n_fits) begin
                r_out_value <= n_sh[CTRL_W-1:0];
            end else begin
                r_out_value <= n_sh[ACC_W-1] ? VAL_MIN : VAL_MAX;
            end
        end
    end

    assign o_value    = r_out_value;
    assign o_overflow = r_out_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // saturated words carry one of the two bounds
    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_value == VAL_MAX || o_value == VAL_MIN))
        else $error("overflow flagged without a bound value");

    // input only stalls when every stage is full
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v))
        else $error("input stalled while pipeline has a bubble");

    // an accepted word lands in stage one
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted word lost at stage one");

    // a stalled stage one holds its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !en[0]) |=> (r_v[0] && $stable(r_s1_t) && $stable(r_s1_k2)))
        else $error("stage one changed while stalled");

endmodule
